### design/mre_pkg.sv
// ----------------------------------------------------------------------------
// mre_pkg
// Shared constants, types and helpers for the matrix multiply / ReLU engine.
// ----------------------------------------------------------------------------
package mre_pkg;

    // Store geometry
    localparam int MAX_DIM = 64;
    localparam int DIM_CAP = (MAX_DIM < 64) ? MAX_DIM : 64;
    localparam int AW      = $clog2(MAX_DIM * MAX_DIM);

    // Fixed field and register widths
    localparam int IDX_W   = 6;
    localparam int DIM_W   = 7;
    localparam int NB_W    = 9;
    localparam int BATCH_W = 8;
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = PROD_W + $clog2(DIM_CAP) + 1;
    localparam int RES_W   = 15;
    localparam int FRAC_W  = 8;

    // Item actions
    localparam logic [1:0] ACT_WR_A    = 2'd0;
    localparam logic [1:0] ACT_WR_B    = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_DEPTH = 2'd2;
    localparam logic [1:0] REG_BATCH = 2'd3;

    // Tag that travels with each operand pair through the MAC pipeline
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_tag_t;

    function automatic logic [AW-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
        elem_addr = AW'(r) * AW'(MAX_DIM) + AW'(c);
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            clamp_dim = DIM_W'(1);
        end else if (v > DIM_W'(DIM_CAP)) begin
            clamp_dim = DIM_W'(DIM_CAP);
        end else begin
            clamp_dim = v;
        end
    endfunction

    function automatic logic [NB_W-1:0] clamp_batch(input logic [NB_W-1:0] v);
        if (v == '0) begin
            clamp_batch = NB_W'(1);
        end else if (v > NB_W'(256)) begin
            clamp_batch = NB_W'(256);
        end else begin
            clamp_batch = v;
        end
    endfunction

endpackage

### design/mre_mac.sv
// ----------------------------------------------------------------------------
// mre_mac
// Two-stage multiply-accumulate with ReLU, Q8.8 rescale and saturation.
// ----------------------------------------------------------------------------
module mre_mac
    import mre_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_tag_t                 in_tag,
    input  logic signed [DATA_W-1:0] in_a,
    input  logic signed [DATA_W-1:0] in_b,
    input  logic                     take,
    output logic                     done,
    output logic [RES_W-1:0]         result
);

    mac_tag_t                   tag_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       done_reg;
    logic                       over;

    always_ff @(posedge aclk) begin
        prod_reg <= in_a * in_b;
        if (tag_reg.vld) begin
            acc_reg <= acc_next;
        end
        if (!aresetn) begin
            tag_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            tag_reg <= in_tag;
            if (tag_reg.vld && tag_reg.last) begin
                done_reg <= 1'b1;
            end else if (take) begin
                done_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        if (tag_reg.first) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // Positive sum: drop the low 8 fraction bits, clip to 15 bits; otherwise zero
    assign over   = |acc_reg[ACC_W-2:RES_W+FRAC_W];
    assign done   = done_reg;
    assign result = (acc_reg[ACC_W-1] || acc_reg == '0) ? '0 :
                    over ? {RES_W{1'b1}} : acc_reg[RES_W+FRAC_W-1:FRAC_W];

endmodule

### design/matmul_relu_engine.sv
// ----------------------------------------------------------------------------
// matmul_relu_engine
// Matrix multiply with ReLU on signed Q8.8 elements held in two block stores.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_*) carries one beat per action: write an A element,
//   write a B element, or compute one result row. Writes give no result. A
//   compute beat for row i < M gives N result beats on the m_* channel,
//   column 0 first, m_last set on column N-1, each tagged with the batch
//   counter. The counter advances after row M-1.
//   A compute beat occupies the engine until its last result is loaded; the A
//   and B stores are each read once per cycle, one pair per multiply-
//   accumulate, with K reads and a pipeline drain per column. The first
//   result leaves the output register once column 0's K pairs are summed.
//   s_ready is high only while no row is in progress; a result waits in the
//   output register while m_ready is low, and the next column's reads stall
//   until that register is free.
//   Reset clears control state, the batch counter and the registers (sizes
//   64, batch count 1); store contents stay undefined until written.
//   Configuration goes through the APB port; write it only while the engine is idle (not enforced).
// ----------------------------------------------------------------------------
module matmul_relu_engine
    import mre_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // APB configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // Input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_action,
    input  logic [IDX_W-1:0]         s_row,
    input  logic [IDX_W-1:0]         s_col,
    input  logic signed [DATA_W-1:0] s_value,
    // Result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [IDX_W-1:0]         m_out_row,
    output logic [IDX_W-1:0]         m_out_col,
    output logic [RES_W-1:0]         m_out_value,
    output logic [BATCH_W-1:0]       m_out_batch,
    output logic                     m_last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    // Configuration registers
    logic [DIM_W-1:0]   rows_reg, cols_reg, depth_reg;
    logic [NB_W-1:0]    nb_reg;
    logic [DIM_W-1:0]   m_cl, n_cl, k_cl;
    logic [NB_W-1:0]    nb_cl;
    logic               cfg_wr;

    // Sequencer
    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   t_reg, t_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [BATCH_W-1:0] batch_reg, batch_next;
    logic [NB_W-1:0]    batch_inc;
    logic               in_beat, out_free, out_load, col_last;
    logic               t_last;

    // Stores
    logic [DATA_W-1:0]  a_mem [MAX_DIM*MAX_DIM];
    logic [DATA_W-1:0]  b_mem [MAX_DIM*MAX_DIM];
    logic [DATA_W-1:0]  a_rdata_reg, b_rdata_reg;
    logic [AW-1:0]      a_raddr, b_raddr, waddr;
    logic               wr_ok;
    mac_tag_t           rd_tag_reg, rd_tag_next;

    // MAC
    logic               mac_done;
    logic [RES_W-1:0]   mac_result;

    // Output register
    logic               m_valid_reg;
    logic [IDX_W-1:0]   m_out_row_reg, m_out_col_reg;
    logic [RES_W-1:0]   m_out_value_reg;
    logic [BATCH_W-1:0] m_out_batch_reg;
    logic               m_last_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= DIM_W'(64);
            cols_reg  <= DIM_W'(64);
            depth_reg <= DIM_W'(64);
            nb_reg    <= NB_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ROWS:  rows_reg  <= pwdata[DIM_W-1:0];
                REG_COLS:  cols_reg  <= pwdata[DIM_W-1:0];
                REG_DEPTH: depth_reg <= pwdata[DIM_W-1:0];
                REG_BATCH: nb_reg    <= pwdata[NB_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROWS:  prdata = 32'(rows_reg);
            REG_COLS:  prdata = 32'(cols_reg);
            REG_DEPTH: prdata = 32'(depth_reg);
            REG_BATCH: prdata = 32'(nb_reg);
            default:   prdata = '0;
        endcase
    end

    // Out-of-range sizes behave as the nearest legal value
    assign m_cl  = clamp_dim(rows_reg);
    assign n_cl  = clamp_dim(cols_reg);
    assign k_cl  = clamp_dim(depth_reg);
    assign nb_cl = clamp_batch(nb_reg);

    // ---------------- stores ----------------
    // Writes happen only in idle; reads happen every cycle, but only read data
    // from a row in progress reaches the MAC, so a same-entry clash is harmless.
    assign waddr   = elem_addr(s_row, s_col);
    assign wr_ok   = (32'(s_row) < MAX_DIM) && (32'(s_col) < MAX_DIM);
    assign a_raddr = elem_addr(row_reg, t_reg);
    assign b_raddr = elem_addr(t_reg, j_reg);

    always_ff @(posedge aclk) begin
        if (in_beat && wr_ok && s_action == ACT_WR_A) begin
            a_mem[waddr] <= s_value;
        end
        if (in_beat && wr_ok && s_action == ACT_WR_B) begin
            b_mem[waddr] <= s_value;
        end
        a_rdata_reg <= a_mem[a_raddr];
        b_rdata_reg <= b_mem[b_raddr];
    end

    // ---------------- sequencer ----------------
    assign s_ready  = (state_reg == S_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == S_DRAIN) && mac_done && out_free;
    assign t_last   = ({1'b0, t_reg} == k_cl - DIM_W'(1));
    assign col_last = ({1'b0, j_reg} == n_cl - DIM_W'(1));
    assign batch_inc = NB_W'(batch_reg) + NB_W'(1);

    always_comb begin
        state_next  = state_reg;
        row_next    = row_reg;
        t_next      = t_reg;
        j_next      = j_reg;
        batch_next  = batch_reg;
        rd_tag_next = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat && s_action == ACT_COMPUTE && {1'b0, s_row} < m_cl) begin
                    row_next   = s_row;
                    t_next     = '0;
                    j_next     = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                // Issue one A/B pair per cycle
                rd_tag_next.vld   = 1'b1;
                rd_tag_next.first = (t_reg == '0);
                rd_tag_next.last  = t_last;
                t_next            = t_reg + IDX_W'(1);
                if (t_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (out_load) begin
                    t_next = '0;
                    if (col_last) begin
                        state_next = S_IDLE;
                        if ({1'b0, row_reg} == m_cl - DIM_W'(1)) begin
                            batch_next = (batch_inc >= nb_cl) ? '0 : batch_inc[BATCH_W-1:0];
                        end
                    end else begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = S_RUN;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        t_reg   <= t_next;
        j_reg   <= j_next;
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            batch_reg  <= '0;
            rd_tag_reg <= '0;
        end else begin
            state_reg  <= state_next;
            batch_reg  <= batch_next;
            rd_tag_reg <= rd_tag_next;
        end
    end

    // ---------------- multiply-accumulate ----------------
    mre_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (rd_tag_reg),
        .in_a    (a_rdata_reg),
        .in_b    (b_rdata_reg),
        .take    (out_load),
        .done    (mac_done),
        .result  (mac_result)
    );

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_out_row_reg   <= row_reg;
            m_out_col_reg   <= j_reg;
            m_out_value_reg <= mac_result;
            m_out_batch_reg <= batch_reg;
            m_last_reg      <= col_last;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = m_out_row_reg;
    assign m_out_col   = m_out_col_reg;
    assign m_out_value = m_out_value_reg;
    assign m_out_batch = m_out_batch_reg;
    assign m_last      = m_last_reg;

`ifndef ASSERT_OFF
    // A finished sum only ever waits while the sequencer drains
    a_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> state_reg == S_DRAIN)
        else $error("MAC result pending outside drain");

    // The last read of a column is followed by a gap in issue
    a_last_then_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_tag_reg.vld && rd_tag_reg.last) |=> !rd_tag_reg.vld)
        else $error("read issued right after last pair of a column");

    // Results never name a column beyond the configured width
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> {1'b0, m_out_col_reg} < n_cl)
        else $error("result column out of range");
`endif

endmodule
